### rtl/sschit_pkg.sv
`default_nettype none
package sschit_pkg;

  localparam int CW  = 32;
  localparam int FB  = 16;
  localparam int DW  = CW + 1;
  localparam int BRW = CW + 2;
  localparam int YW  = CW + 3;
  localparam int AW  = CW + 4;
  localparam int MW  = 2 * AW;
  localparam int PW  = 2 * MW;
  localparam int DG  = 18;
  localparam int MD  = MW / DG;
  localparam int PSW = 108;
  localparam int SSW = 88;
  localparam int LSW = 56;

  // 1e-6 in Q32.32, rounded
  localparam longint EPS_SQ = 4295;

  typedef struct packed {
    logic signed [CW-1:0] start_x;
    logic signed [CW-1:0] start_y;
    logic signed [CW-1:0] start_z;
    logic signed [CW-1:0] end_x;
    logic signed [CW-1:0] end_y;
    logic signed [CW-1:0] end_z;
    logic signed [CW-1:0] axis_x;
    logic signed [CW-1:0] axis_z;
    logic signed [CW-1:0] cyl_radius;
    logic signed [CW-1:0] base_height;
    logic signed [CW-1:0] cyl_tallness;
  } sschit_in_t;

  typedef struct packed {
    logic                 hit;
    logic        [FB:0]   entry_fraction;
    logic signed [CW-1:0] point_x;
    logic signed [CW-1:0] point_y;
    logic signed [CW-1:0] point_z;
  } sschit_out_t;

  typedef struct packed {
    logic signed [CW-1:0] sx;
    logic signed [CW-1:0] sy;
    logic signed [CW-1:0] sz;
    logic signed [CW-1:0] ex;
    logic signed [CW-1:0] ey;
    logic signed [CW-1:0] ez;
    logic signed [DW-1:0] dx;
    logic signed [DW-1:0] dy;
    logic signed [DW-1:0] dz;
  } sschit_geo_t;

  typedef struct packed {
    logic                 miss;
    logic signed [MW-1:0] qa;
    logic signed [MW-1:0] qb;
    logic signed [MW-1:0] qc;
    logic signed [MW-1:0] a2sq;
    logic signed [MW-1:0] a2e;
    logic signed [MW-1:0] esq;
    logic signed [MW-1:0] a1sq;
    logic signed [MW-1:0] a1e;
    logic signed [AW-1:0] a1;
    logic signed [AW-1:0] a2;
    logic signed [AW-1:0] e;
    sschit_geo_t          geo;
  } sschit_coef_t;

  typedef struct packed {
    logic                  hit;
    logic        [FB:0]    k;
    logic signed [PSW-1:0] p;
    logic signed [SSW-1:0] s;
    logic signed [LSW-1:0] l;
    logic signed [MW-1:0]  qa;
    logic signed [MW-1:0]  qb;
    logic signed [AW-1:0]  a1;
    logic signed [AW-1:0]  e;
    sschit_geo_t           geo;
  } sschit_srch_t;

endpackage
`default_nettype wire

### rtl/sschit_mul.sv
`default_nettype none
module sschit_mul (
  input  logic                           clk,
  input  logic                           en,
  input  logic signed [sschit_pkg::MW-1:0] a,
  input  logic signed [sschit_pkg::MW-1:0] b,
  output logic signed [sschit_pkg::PW-1:0] p
);
  import sschit_pkg::*;

  logic signed [MW-1:0] a_r [MD-1];
  logic signed [MW-1:0] b_r [MD-1];
  logic signed [PW-1:0] acc_r [MD];

  // one 18-bit digit of b per stage, top digit signed
  function automatic logic signed [PW-1:0] pp(input logic signed [MW-1:0] x,
                                              input logic signed [MW-1:0] y,
                                              input int i);
    logic signed [DG:0]    d;
    logic signed [MW+DG:0] prod;
    logic signed [PW-1:0]  ext;
    if (i == MD - 1) begin
      d = {y[MW-1], y[i*DG +: DG]};
    end else begin
      d = {1'b0, y[i*DG +: DG]};
    end
    prod = x * d;
    ext  = prod;
    return ext <<< (DG * i);
  endfunction

  always_ff @(posedge clk) begin
    if (en) begin
      a_r[0]   <= a;
      b_r[0]   <= b;
      acc_r[0] <= pp(a, b, 0);
      for (int i = 1; i < MD - 1; i++) begin
        a_r[i] <= a_r[i-1];
        b_r[i] <= b_r[i-1];
      end
      for (int i = 1; i < MD; i++) begin
        acc_r[i] <= acc_r[i-1] + pp(a_r[i-1], b_r[i-1], i);
      end
    end
  end

  assign p = acc_r[MD-1];

endmodule
`default_nettype wire

### rtl/sschit_front.sv
`default_nettype none
module sschit_front (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       en,
  input  logic                       in_valid,
  input  sschit_pkg::sschit_in_t     in_data,
  input  logic [sschit_pkg::CW-2:0]  proj_rad,
  output logic                       coef_valid,
  output sschit_pkg::sschit_coef_t   coef
);
  import sschit_pkg::*;

  // stage 0: request register
  logic       v0_r;
  sschit_in_t i0_r;

  // stage 1: differences and inflated bounds
  logic                  v1_r, miss1_r, miss1_nxt;
  sschit_geo_t           g1_r, g1_nxt;
  logic signed [DW-1:0]  hx1_r, hz1_r, hx1_nxt, hz1_nxt;
  logic signed [BRW-1:0] br1_r, br1_nxt;
  logic signed [YW-1:0]  lowy1_r, highy1_r, lowy1_nxt, highy1_nxt;

  // stage 2: squares, slab interval
  logic                    v2_r, miss2_r, miss2_nxt;
  sschit_geo_t             g2_r;
  logic signed [2*DW-1:0]  dxx2_r, dzz2_r, hxx2_r, hzz2_r, hxdx2_r, hzdz2_r;
  logic signed [2*BRW-1:0] brr2_r;
  logic signed [AW-1:0]    a1_2_r, a2_2_r, e2_r, a1_2_nxt, a2_2_nxt, e2_nxt;

  // stage 3: sums, slab products
  logic                 v3_r, miss3_r;
  sschit_geo_t          g3_r;
  logic signed [MW-1:0] ll3_r, hh3_r, qb3_r, rr3_r, ll3_nxt, hh3_nxt, qb3_nxt, rr3_nxt;
  logic signed [MW-1:0] a2sq3_r, a2e3_r, esq3_r, a1sq3_r, a1e3_r;
  logic signed [AW-1:0] a1_3_r, a2_3_r, e3_r;

  // stage 4: quadratic selection
  logic         v4_r;
  sschit_coef_t c4_r, c4_nxt;

  always_comb begin
    g1_nxt.sx = i0_r.start_x;
    g1_nxt.sy = i0_r.start_y;
    g1_nxt.sz = i0_r.start_z;
    g1_nxt.ex = i0_r.end_x;
    g1_nxt.ey = i0_r.end_y;
    g1_nxt.ez = i0_r.end_z;
    g1_nxt.dx = {i0_r.end_x[CW-1], i0_r.end_x} - {i0_r.start_x[CW-1], i0_r.start_x};
    g1_nxt.dy = {i0_r.end_y[CW-1], i0_r.end_y} - {i0_r.start_y[CW-1], i0_r.start_y};
    g1_nxt.dz = {i0_r.end_z[CW-1], i0_r.end_z} - {i0_r.start_z[CW-1], i0_r.start_z};
    hx1_nxt = {i0_r.start_x[CW-1], i0_r.start_x} - {i0_r.axis_x[CW-1], i0_r.axis_x};
    hz1_nxt = {i0_r.start_z[CW-1], i0_r.start_z} - {i0_r.axis_z[CW-1], i0_r.axis_z};
    br1_nxt = {{2{i0_r.cyl_radius[CW-1]}}, i0_r.cyl_radius} + {3'b0, proj_rad};
    lowy1_nxt = {{3{i0_r.base_height[CW-1]}}, i0_r.base_height} - {4'b0, proj_rad};
    highy1_nxt = {{3{i0_r.base_height[CW-1]}}, i0_r.base_height}
               + {{3{i0_r.cyl_tallness[CW-1]}}, i0_r.cyl_tallness} + {4'b0, proj_rad};
    miss1_nxt = ($signed(i0_r.cyl_radius) <= 0) || ($signed(i0_r.cyl_tallness) <= 0);
  end

  logic signed [AW-1:0] syx, lox, hix, dyx;
  logic                 fmiss;

  always_comb begin
    syx = g1_r.sy;
    lox = lowy1_r;
    hix = highy1_r;
    dyx = g1_r.dy;
    fmiss = 1'b0;
    if (g1_r.dy == '0) begin
      a1_2_nxt = '0;
      a2_2_nxt = AW'(1);
      e2_nxt   = AW'(1);
      fmiss    = (syx < lox) || (syx > hix);
    end else if (dyx > 0) begin
      a1_2_nxt = lox - syx;
      a2_2_nxt = hix - syx;
      e2_nxt   = dyx;
    end else begin
      a1_2_nxt = syx - hix;
      a2_2_nxt = syx - lox;
      e2_nxt   = -dyx;
    end
    miss2_nxt = miss1_r || fmiss;
  end

  logic signed [MW-1:0] dxx_x, dzz_x, hxx_x, hzz_x, hxdx_x, hzdz_x, brr_x;

  always_comb begin
    dxx_x  = dxx2_r;
    dzz_x  = dzz2_r;
    hxx_x  = hxx2_r;
    hzz_x  = hzz2_r;
    hxdx_x = hxdx2_r;
    hzdz_x = hzdz2_r;
    brr_x  = brr2_r;
    ll3_nxt = dxx_x + dzz_x;
    hh3_nxt = hxx_x + hzz_x;
    qb3_nxt = hxdx_x + hzdz_x;
    rr3_nxt = brr_x;
  end

  logic nearv;

  always_comb begin
    nearv       = ll3_r <= EPS_SQ;
    c4_nxt.a2sq = a2sq3_r;
    c4_nxt.a2e  = a2e3_r;
    c4_nxt.esq  = esq3_r;
    c4_nxt.a1sq = a1sq3_r;
    c4_nxt.a1e  = a1e3_r;
    c4_nxt.a1   = a1_3_r;
    c4_nxt.a2   = a2_3_r;
    c4_nxt.e    = e3_r;
    c4_nxt.geo  = g3_r;
    // near-vertical motion: roots at 0 and 1
    if (nearv) begin
      c4_nxt.qa = MW'(2);
      c4_nxt.qb = '1;
      c4_nxt.qc = '0;
    end else begin
      c4_nxt.qa = ll3_r;
      c4_nxt.qb = qb3_r;
      c4_nxt.qc = hh3_r - rr3_r;
    end
    c4_nxt.miss = miss3_r || (nearv && (hh3_r > rr3_r));
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v0_r <= 1'b0;
      v1_r <= 1'b0;
      v2_r <= 1'b0;
      v3_r <= 1'b0;
      v4_r <= 1'b0;
    end else if (en) begin
      v0_r <= in_valid;
      v1_r <= v0_r;
      v2_r <= v1_r;
      v3_r <= v2_r;
      v4_r <= v3_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      i0_r <= in_data;

      g1_r     <= g1_nxt;
      hx1_r    <= hx1_nxt;
      hz1_r    <= hz1_nxt;
      br1_r    <= br1_nxt;
      lowy1_r  <= lowy1_nxt;
      highy1_r <= highy1_nxt;
      miss1_r  <= miss1_nxt;

      g2_r    <= g1_r;
      dxx2_r  <= g1_r.dx * g1_r.dx;
      dzz2_r  <= g1_r.dz * g1_r.dz;
      hxx2_r  <= hx1_r * hx1_r;
      hzz2_r  <= hz1_r * hz1_r;
      hxdx2_r <= hx1_r * g1_r.dx;
      hzdz2_r <= hz1_r * g1_r.dz;
      brr2_r  <= br1_r * br1_r;
      a1_2_r  <= a1_2_nxt;
      a2_2_r  <= a2_2_nxt;
      e2_r    <= e2_nxt;
      miss2_r <= miss2_nxt;

      g3_r    <= g2_r;
      ll3_r   <= ll3_nxt;
      hh3_r   <= hh3_nxt;
      qb3_r   <= qb3_nxt;
      rr3_r   <= rr3_nxt;
      a2sq3_r <= a2_2_r * a2_2_r;
      a2e3_r  <= a2_2_r * e2_r;
      esq3_r  <= e2_r * e2_r;
      a1sq3_r <= a1_2_r * a1_2_r;
      a1e3_r  <= a1_2_r * e2_r;
      a1_3_r  <= a1_2_r;
      a2_3_r  <= a2_2_r;
      e3_r    <= e2_r;
      miss3_r <= miss2_r;

      c4_r <= c4_nxt;
    end
  end

  assign coef_valid = v4_r;
  assign coef       = c4_r;

endmodule
`default_nettype wire

### rtl/sschit_srch.sv
`default_nettype none
module sschit_srch #(
  parameter int BIT = 0
) (
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     en,
  input  logic                     in_valid,
  input  sschit_pkg::sschit_srch_t in_st,
  output logic                     out_valid,
  output sschit_pkg::sschit_srch_t out_st
);
  import sschit_pkg::*;

  logic                  valid_r;
  sschit_srch_t          st_r, st_nxt;
  logic signed [PSW-1:0] p_c, s_px, qa_px, qb_px;
  logic signed [SSW-1:0] s_c, qa_sx, qb_sx, slope;
  logic signed [LSW-1:0] l_c, e_lx, a1_lx, lin;
  logic                  take;

  // try k + 2^BIT: P, qa*k and e*k are updated by shifts and adds
  always_comb begin
    s_px  = in_st.s;
    qa_px = in_st.qa;
    qb_px = in_st.qb;
    qa_sx = in_st.qa;
    qb_sx = in_st.qb;
    e_lx  = in_st.e;
    a1_lx = in_st.a1;
    p_c   = in_st.p + (s_px <<< (BIT + 1)) + (qa_px <<< (2 * BIT))
          + (qb_px <<< (BIT + FB + 1));
    s_c   = in_st.s + (qa_sx <<< BIT);
    slope = s_c + (qb_sx <<< FB);
    l_c   = in_st.l + (e_lx <<< BIT);
    lin   = l_c - (a1_lx <<< FB);
    take  = !in_st.k[FB] && ((!p_c[PSW-1] && (slope <= 0)) || (lin <= 0));
    st_nxt = in_st;
    if (take) begin
      st_nxt.k[BIT] = 1'b1;
      st_nxt.p      = p_c;
      st_nxt.s      = s_c;
      st_nxt.l      = l_c;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (en) begin
      valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      st_r <= st_nxt;
    end
  end

  assign out_valid = valid_r;
  assign out_st    = st_r;

endmodule
`default_nettype wire

### rtl/swept_sphere_cylinder_hit_core.sv
// Swept sphere against an upright cylinder, Q16.16 fixed point.
// Input channel in_valid/in_ready/in_data carries one request: segment start
// and end plus the cylinder. Result channel out_valid/out_ready/out_data gives
// hit, the Q1.16 entry fraction and the contact point (end point on a miss).
// cfg_valid/cfg_ready/cfg_data writes the projectile radius; cfg_ready is
// always high. Write it only while no request is in flight.
// Throughput: one request per cycle while the pipeline is not held. The depth
// comes from the setup stages, the four-stage digit multipliers for the root
// tests and a 17-stage bit-per-stage search of the entry fraction.
// All stages advance together whenever the output register is empty or being
// taken; while out_valid is high and out_ready is low the whole pipeline holds
// and in_ready is low, so nothing is lost or repeated.
// Reset clears all valid bits and sets the projectile radius to zero.
`default_nettype none
module swept_sphere_cylinder_hit_core (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       cfg_valid,
  output logic                       cfg_ready,
  input  logic [sschit_pkg::CW-2:0]  cfg_data,
  input  logic                       in_valid,
  output logic                       in_ready,
  input  sschit_pkg::sschit_in_t     in_data,
  output logic                       out_valid,
  input  logic                       out_ready,
  output sschit_pkg::sschit_out_t    out_data
);
  import sschit_pkg::*;

  localparam logic [FB:0] ONE = (FB + 1)'(1) << FB;

  logic          en;
  logic [CW-2:0] prad_r;

  logic         coef_valid;
  sschit_coef_t coef;

  assign en        = !out_valid || out_ready;
  assign in_ready  = en;
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      prad_r <= '0;
    end else if (cfg_valid) begin
      prad_r <= cfg_data;
    end
  end

  sschit_front u_front (
    .clk        (clk),
    .rst_n      (rst_n),
    .en         (en),
    .in_valid   (in_valid),
    .in_data    (in_data),
    .proj_rad   (prad_r),
    .coef_valid (coef_valid),
    .coef       (coef)
  );

  // wide products for the discriminant and the root tests
  logic signed [MW-1:0] a1_m, a2_m, e_m;
  logic signed [PW-1:0] m_qbqb, m_qaqc, m_qa_a2sq, m_qb_a2e, m_qc_esq;
  logic signed [PW-1:0] m_qa_a1sq, m_qb_a1e, m_qa_a2, m_qa_a1, m_qb_e;

  assign a1_m = coef.a1;
  assign a2_m = coef.a2;
  assign e_m  = coef.e;

  sschit_mul u_qbqb  (.clk(clk), .en(en), .a(coef.qb), .b(coef.qb),   .p(m_qbqb));
  sschit_mul u_qaqc  (.clk(clk), .en(en), .a(coef.qa), .b(coef.qc),   .p(m_qaqc));
  sschit_mul u_qa2sq (.clk(clk), .en(en), .a(coef.qa), .b(coef.a2sq), .p(m_qa_a2sq));
  sschit_mul u_qb2e  (.clk(clk), .en(en), .a(coef.qb), .b(coef.a2e),  .p(m_qb_a2e));
  sschit_mul u_qcesq (.clk(clk), .en(en), .a(coef.qc), .b(coef.esq),  .p(m_qc_esq));
  sschit_mul u_qa1sq (.clk(clk), .en(en), .a(coef.qa), .b(coef.a1sq), .p(m_qa_a1sq));
  sschit_mul u_qb1e  (.clk(clk), .en(en), .a(coef.qb), .b(coef.a1e),  .p(m_qb_a1e));
  sschit_mul u_qa2   (.clk(clk), .en(en), .a(coef.qa), .b(a2_m),      .p(m_qa_a2));
  sschit_mul u_qa1   (.clk(clk), .en(en), .a(coef.qa), .b(a1_m),      .p(m_qa_a1));
  sschit_mul u_qbe   (.clk(clk), .en(en), .a(coef.qb), .b(e_m),       .p(m_qb_e));

  logic         cv_r [MD];
  sschit_coef_t cd_r [MD];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cv_r <= '{default: 1'b0};
    end else if (en) begin
      cv_r[0] <= coef_valid;
      for (int i = 1; i < MD; i++) begin
        cv_r[i] <= cv_r[i-1];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      cd_r[0] <= coef;
      for (int i = 1; i < MD; i++) begin
        cd_r[i] <= cd_r[i-1];
      end
    end
  end

  // quadratic values and slopes at the slab ends
  logic                 e1v_r;
  sschit_coef_t         e1c_r;
  logic signed [PW-1:0] disc_r, v2_r, v1_r, s2l_r, s1l_r;
  logic signed [PW-1:0] disc_nxt, v2_nxt, v1_nxt, s2l_nxt, s1l_nxt;
  logic signed [MW+1:0] vone_r, slone_r, vone_nxt, slone_nxt;
  logic signed [MW+1:0] qa_w, qb_w, qc_w;

  always_comb begin
    qa_w      = cd_r[MD-1].qa;
    qb_w      = cd_r[MD-1].qb;
    qc_w      = cd_r[MD-1].qc;
    disc_nxt  = m_qbqb - m_qaqc;
    v2_nxt    = m_qa_a2sq + (m_qb_a2e <<< 1) + m_qc_esq;
    v1_nxt    = m_qa_a1sq + (m_qb_a1e <<< 1) + m_qc_esq;
    s2l_nxt   = m_qa_a2 + m_qb_e;
    s1l_nxt   = m_qa_a1 + m_qb_e;
    vone_nxt  = qa_w + (qb_w <<< 1) + qc_w;
    slone_nxt = qa_w + qb_w;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      e1v_r <= 1'b0;
    end else if (en) begin
      e1v_r <= cv_r[MD-1];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      e1c_r   <= cd_r[MD-1];
      disc_r  <= disc_nxt;
      v2_r    <= v2_nxt;
      v1_r    <= v1_nxt;
      s2l_r   <= s2l_nxt;
      s1l_r   <= s1l_nxt;
      vone_r  <= vone_nxt;
      slone_r <= slone_nxt;
    end
  end

  // hit decision and search seed
  logic                  st0v_r;
  sschit_srch_t          st0_r, st0_nxt;
  logic signed [PSW-1:0] qc_p;
  logic                  lo_le_a2, lo_le_one, hi_ge_a1, hi_ge_zero;

  always_comb begin
    lo_le_a2   = (v2_r <= 0) || (s2l_r >= 0);
    lo_le_one  = (vone_r <= 0) || (slone_r >= 0);
    hi_ge_a1   = (s1l_r <= 0) || (v1_r <= 0);
    hi_ge_zero = (e1c_r.qb <= 0) || (e1c_r.qc <= 0);
    qc_p       = e1c_r.qc;
    st0_nxt.hit = !e1c_r.miss && !disc_r[PW-1] && lo_le_a2 && lo_le_one && hi_ge_a1
                && (e1c_r.a1 <= e1c_r.e) && hi_ge_zero && (e1c_r.a2 >= 0);
    st0_nxt.k   = '0;
    st0_nxt.p   = qc_p <<< (2 * FB);
    st0_nxt.s   = '0;
    st0_nxt.l   = '0;
    st0_nxt.qa  = e1c_r.qa;
    st0_nxt.qb  = e1c_r.qb;
    st0_nxt.a1  = e1c_r.a1;
    st0_nxt.e   = e1c_r.e;
    st0_nxt.geo = e1c_r.geo;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st0v_r <= 1'b0;
    end else if (en) begin
      st0v_r <= e1v_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      st0_r <= st0_nxt;
    end
  end

  // entry fraction, one bit per stage from the top
  logic         sv_i [FB+1];
  sschit_srch_t st_i [FB+1];
  logic         sv_o [FB+1];
  sschit_srch_t st_o [FB+1];

  assign sv_i[0] = st0v_r;
  assign st_i[0] = st0_r;

  for (genvar g = 0; g <= FB; g++) begin : g_srch
    if (g > 0) begin : g_link
      assign sv_i[g] = sv_o[g-1];
      assign st_i[g] = st_o[g-1];
    end
    sschit_srch #(.BIT(FB - g)) u_srch (
      .clk       (clk),
      .rst_n     (rst_n),
      .en        (en),
      .in_valid  (sv_i[g]),
      .in_st     (st_i[g]),
      .out_valid (sv_o[g]),
      .out_st    (st_o[g])
    );
  end

  // contact point and output register
  logic                    out_valid_r;
  sschit_out_t             out_r, out_nxt;
  sschit_srch_t            fin;
  logic signed [DW+FB:0]   prod_x, prod_y, prod_z;
  logic signed [FB+1:0]    frac_s;
  logic signed [CW-1:0]    px, py, pz;

  always_comb begin
    fin    = st_o[FB];
    frac_s = {1'b0, fin.k};
    prod_x = fin.geo.dx * frac_s;
    prod_y = fin.geo.dy * frac_s;
    prod_z = fin.geo.dz * frac_s;
    px     = fin.geo.sx + prod_x[CW+FB-1:FB];
    py     = fin.geo.sy + prod_y[CW+FB-1:FB];
    pz     = fin.geo.sz + prod_z[CW+FB-1:FB];
    if (fin.hit) begin
      out_nxt.hit            = 1'b1;
      out_nxt.entry_fraction = fin.k;
      out_nxt.point_x        = px;
      out_nxt.point_y        = py;
      out_nxt.point_z        = pz;
    end else begin
      out_nxt.hit            = 1'b0;
      out_nxt.entry_fraction = ONE;
      out_nxt.point_x        = fin.geo.ex;
      out_nxt.point_y        = fin.geo.ey;
      out_nxt.point_z        = fin.geo.ez;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (en) begin
      out_valid_r <= sv_o[FB];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      out_r <= out_nxt;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_r;

endmodule
`default_nettype wire
